### sv/evse_pilot_state_controller_unit_defines.svh
// Assertion helpers for the pilot state controller.
`ifndef EVSE_PILOT_STATE_CONTROLLER_UNIT_DEFINES_SVH
`define EVSE_PILOT_STATE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EPSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pilot controller: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define EPSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pilot controller: next-cycle check failed");

`endif

### sv/evse_psc_pkg.sv
`timescale 1ns / 1ps

package evse_psc_pkg;

  typedef enum logic [2:0] {
    ST_UNDEF      = 3'd0,
    ST_IDLE       = 3'd1,
    ST_CONNECT    = 3'd2,
    ST_WAIT       = 3'd3,
    ST_CHARGE     = 3'd4,
    ST_FAN        = 3'd5,
    ST_DISCONNECT = 3'd6,
    ST_PAUSED     = 3'd7
  } pilot_state_t;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  localparam logic [6:0] CUR_MAX   = 7'd80;
  localparam int         CUR_SPLIT = 50;

  // next state, indexed [current][measured or paused]
  localparam logic [2:0] NEXT_TBL [0:7][0:7] = '{
    '{ST_UNDEF, ST_IDLE,  ST_UNDEF,   ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_UNDEF},
    '{ST_IDLE,  ST_IDLE,  ST_CONNECT, ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_IDLE,  ST_WAIT,    ST_WAIT,  ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_IDLE,  ST_WAIT,    ST_WAIT,  ST_CHARGE, ST_FAN,   ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_UNDEF, ST_UNDEF,   ST_WAIT,  ST_CHARGE, ST_FAN,   ST_IDLE, ST_PAUSED},
    '{ST_UNDEF, ST_UNDEF, ST_UNDEF,   ST_WAIT,  ST_CHARGE, ST_FAN,   ST_IDLE, ST_PAUSED},
    '{ST_UNDEF, ST_IDLE,  ST_CONNECT, ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_IDLE,  ST_CONNECT, ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE}
  };

  // minimum stable age in centiseconds, same indexing
  localparam logic [11:0] MIN_AGE_TBL [0:7][0:7] = '{
    '{12'd0, 12'd100, 12'd0,   12'd0, 12'd0,   12'd0,   12'd10, 12'd0},
    '{12'd0, 12'd0,   12'd100, 12'd0, 12'd0,   12'd0,   12'd0,  12'd0},
    '{12'd0, 12'd0,   12'd100, 12'd0, 12'd0,   12'd0,   12'd0,  12'd0},
    '{12'd0, 12'd0,   12'd0,   12'd0, 12'd100, 12'd100, 12'd0,  12'd0},
    '{12'd0, 12'd0,   12'd0,   12'd0, 12'd0,   12'd0,   12'd10, 12'd0},
    '{12'd0, 12'd0,   12'd0,   12'd0, 12'd0,   12'd0,   12'd10, 12'd0},
    '{12'd0, 12'd0,   12'd10,  12'd0, 12'd0,   12'd0,   12'd0,  12'd0},
    '{12'd0, 12'd0,   12'd10,  12'd0, 12'd0,   12'd0,   12'd10, 12'd2500}
  };

  // wait, charge, fan offer power; charge, fan, paused close the relay
  localparam logic [7:0] OFFERS_POWER = 8'b0011_1000;
  localparam logic [7:0] RELAY_FOR    = 8'b1011_0000;

  typedef struct packed {
    logic [2:0] state_now;
    logic       state_changed;
    logic       drive_valid;
    logic [9:0] pilot_compare;
    logic       relay_on;
    logic       relay_toggled;
    logic       power_offered;
  } step_res_t;

endpackage

### sv/evse_psc_duty.sv
`timescale 1ns / 1ps

module evse_psc_duty #(
  parameter int PWM_TOP = 1000
) (
  input  logic [6:0] current_amps,
  output logic [9:0] duty
);
  import evse_psc_pkg::*;

  localparam int TOP5  = PWM_TOP / 5;
  localparam int TOP10 = PWM_TOP / 10;
  localparam int LUT_N = 81;

  function automatic int duty_calc(input int c);
    int r;
    if (c < CUR_SPLIT) r = (c * TOP5 + 6) / 12;
    else               r = (c * TOP10 + 160 * TOP10 + 12) / 25;
    return r;
  endfunction

  logic [9:0] lut [LUT_N];
  logic [6:0] amps_clamped;

  for (genvar g = 0; g < LUT_N; g++) begin : g_lut
    assign lut[g] = 10'(duty_calc(g));
  end

  assign amps_clamped = (current_amps > CUR_MAX) ? CUR_MAX : current_amps;
  assign duty = lut[amps_clamped];

endmodule

### sv/evse_psc_step.sv
`timescale 1ns / 1ps

module evse_psc_step #(
  parameter int PWM_TOP = 1000
) (
  input  logic                     opcode,
  input  logic                     in_range,
  input  logic [2:0]               state_cur,
  input  logic                     relay_cur,
  input  logic [2:0]               measured_state,
  input  logic [14:0]              measured_age,
  input  logic                     paused,
  input  logic                     conditions_ok,
  input  logic [9:0]               duty,
  output evse_psc_pkg::step_res_t  res
);
  import evse_psc_pkg::*;

  localparam logic [9:0] TOP_CMP = 10'(PWM_TOP);

  logic [2:0]  col;
  logic [2:0]  nx;
  logic [11:0] min_age;
  logic        move;
  logic        refresh_drive;
  logic        relay_new;
  logic [2:0]  st_new;

  always_comb begin
    col           = paused ? ST_PAUSED : measured_state;
    nx            = NEXT_TBL[state_cur][col];
    min_age       = MIN_AGE_TBL[state_cur][col];
    move          = (opcode == OP_STEP) && (measured_age >= 15'(min_age)) &&
                    (nx != state_cur) && conditions_ok;
    refresh_drive = (opcode == OP_REFRESH) && OFFERS_POWER[state_cur];
    st_new        = move ? nx : state_cur;
    relay_new     = move ? RELAY_FOR[nx] : relay_cur;

    res = '0;
    if (in_range) begin
      res.state_now     = st_new;
      res.state_changed = move;
      res.drive_valid   = move || refresh_drive;
      if (move) res.pilot_compare = OFFERS_POWER[nx] ? duty : TOP_CMP;
      else if (refresh_drive) res.pilot_compare = duty;
      res.relay_on      = relay_new;
      res.relay_toggled = relay_new != relay_cur;
      res.power_offered = OFFERS_POWER[st_new];
    end
  end

endmodule

### sv/evse_pilot_state_controller_unit.sv
`timescale 1ns / 1ps
// Pilot state controller for a multi-port charging station.
// Input channel (in_valid/in_ready): one item per transfer, naming a port and
// either a state step (opcode 0) or a pilot duty refresh (opcode 1).
// Output channel (out_valid/out_ready): exactly one result per input item,
// in input order: new port state, change flag, pilot compare, relay command.
// Stages: the input register loads on the input transfer; table lookup, duty
// table and per-port state update then feed the result register, which loads
// when it is empty or out_ready is high, and then raises out_valid.
// Throughput: 1 item per cycle while out_ready is high; per-port state is
// written as an item moves into the result register, so the following item
// sees it directly. When out_ready is low the result register holds and the
// input register keeps accepting until it is full, then in_ready drops.
// Reset: every port goes to idle with its relay off; both stages empty.
// Ports at or above PORT_COUNT return zeros and change no state.
`include "evse_pilot_state_controller_unit_defines.svh"

module evse_pilot_state_controller_unit #(
  parameter int PORT_COUNT = 6,
  parameter int PWM_TOP    = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [2:0]  port,
  input  logic [2:0]  measured_state,
  input  logic [14:0] measured_age,
  input  logic        paused,
  input  logic        conditions_ok,
  input  logic [6:0]  current_amps,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  port_out,
  output logic [2:0]  state_now,
  output logic        state_changed,
  output logic        drive_valid,
  output logic [9:0]  pilot_compare,
  output logic        relay_on,
  output logic        relay_toggled,
  output logic        power_offered
);
  import evse_psc_pkg::*;

  localparam int NSLOT  = (PORT_COUNT < 8) ? PORT_COUNT : 8;
  localparam int SLOT_W = (NSLOT > 1) ? $clog2(NSLOT) : 1;

  logic             s1_valid;
  logic             s1_opcode;
  logic [2:0]       s1_port;
  logic [2:0]       s1_meas;
  logic [14:0]      s1_age;
  logic             s1_paused;
  logic             s1_ok;
  logic [6:0]       s1_amps;

  logic [2:0]       port_state  [NSLOT];
  logic             relay_state [NSLOT];

  logic             advance;
  logic             s1_fire;
  logic             in_range;
  logic [SLOT_W-1:0] slot;
  logic [2:0]       state_cur;
  logic             relay_cur;
  logic [9:0]       duty;
  step_res_t        res;

  assign advance  = !out_valid || out_ready;
  assign s1_fire  = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  assign in_range  = 32'(s1_port) < PORT_COUNT;
  assign slot      = SLOT_W'(s1_port);
  assign state_cur = in_range ? port_state[slot] : ST_IDLE;
  assign relay_cur = in_range ? relay_state[slot] : 1'b0;

  evse_psc_duty #(.PWM_TOP(PWM_TOP)) u_duty (
    .current_amps (s1_amps),
    .duty         (duty)
  );

  evse_psc_step #(.PWM_TOP(PWM_TOP)) u_step (
    .opcode         (s1_opcode),
    .in_range       (in_range),
    .state_cur      (state_cur),
    .relay_cur      (relay_cur),
    .measured_state (s1_meas),
    .measured_age   (s1_age),
    .paused         (s1_paused),
    .conditions_ok  (s1_ok),
    .duty           (duty),
    .res            (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        port_state[i]  <= ST_IDLE;
        relay_state[i] <= 1'b0;
      end
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
      if (s1_fire && in_range) begin
        port_state[slot]  <= res.state_now;
        relay_state[slot] <= res.relay_on;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_opcode <= opcode;
      s1_port   <= port;
      s1_meas   <= measured_state;
      s1_age    <= measured_age;
      s1_paused <= paused;
      s1_ok     <= conditions_ok;
      s1_amps   <= current_amps;
    end
    if (s1_fire) begin
      port_out      <= s1_port;
      state_now     <= res.state_now;
      state_changed <= res.state_changed;
      drive_valid   <= res.drive_valid;
      pilot_compare <= res.pilot_compare;
      relay_on      <= res.relay_on;
      relay_toggled <= res.relay_toggled;
      power_offered <= res.power_offered;
    end
  end

  `EPSC_ASSERT_IMPL(a_toggle_needs_move, clk, rst, out_valid && relay_toggled, state_changed)
  `EPSC_ASSERT_IMPL(a_move_drives, clk, rst, out_valid && state_changed, drive_valid)
  `EPSC_ASSERT_IMPL(a_idle_cmp_zero, clk, rst, out_valid && !drive_valid, pilot_compare == 10'd0)
  `EPSC_ASSERT_IMPL(a_range_quiet, clk, rst, out_valid && (32'(port_out) >= PORT_COUNT),
                    !drive_valid && !relay_on && (state_now == ST_UNDEF))
  `EPSC_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !advance, s1_valid)

endmodule

### bench/tb_evse_pilot_state_controller_unit.sv
`timescale 1ns / 1ps

module tb_evse_pilot_state_controller_unit;
  import evse_psc_pkg::*;

  localparam int NUM_PORTS   = 6;
  localparam int PWM_PERIOD  = 1000;
  localparam int AMPS_CAP    = 80;
  localparam int AMPS_KNEE   = 50;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT = 200000;

  // next state, [current][measured, or paused column]
  localparam logic [2:0] NEXT_ST [0:7][0:7] = '{
    '{ST_UNDEF, ST_IDLE,  ST_UNDEF,   ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_UNDEF},
    '{ST_IDLE,  ST_IDLE,  ST_CONNECT, ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_IDLE,  ST_WAIT,    ST_WAIT,  ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_IDLE,  ST_WAIT,    ST_WAIT,  ST_CHARGE, ST_FAN,   ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_UNDEF, ST_UNDEF,   ST_WAIT,  ST_CHARGE, ST_FAN,   ST_IDLE, ST_PAUSED},
    '{ST_UNDEF, ST_UNDEF, ST_UNDEF,   ST_WAIT,  ST_CHARGE, ST_FAN,   ST_IDLE, ST_PAUSED},
    '{ST_UNDEF, ST_IDLE,  ST_CONNECT, ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE},
    '{ST_UNDEF, ST_IDLE,  ST_CONNECT, ST_UNDEF, ST_UNDEF,  ST_UNDEF, ST_IDLE, ST_IDLE}
  };

  // minimum stable age in centiseconds, same indexing
  localparam int HOLD_MIN [0:7][0:7] = '{
    '{0, 100, 0,   0, 0,   0,   10, 0},
    '{0, 0,   100, 0, 0,   0,   0,  0},
    '{0, 0,   100, 0, 0,   0,   0,  0},
    '{0, 0,   0,   0, 100, 100, 0,  0},
    '{0, 0,   0,   0, 0,   0,   10, 0},
    '{0, 0,   0,   0, 0,   0,   10, 0},
    '{0, 0,   10,  0, 0,   0,   0,  0},
    '{0, 0,   10,  0, 0,   0,   10, 2500}
  };

  typedef struct packed {
    logic        opcode;
    logic [2:0]  port;
    logic [2:0]  meas;
    logic [14:0] age;
    logic        paused;
    logic        ok;
    logic [6:0]  amps;
  } pilot_item_t;

  typedef struct packed {
    logic [2:0] port;
    logic [2:0] state;
    logic       changed;
    logic       drive;
    logic [9:0] compare;
    logic       relay;
    logic       toggled;
    logic       offered;
  } pilot_result_t;

  typedef struct packed {
    logic [NUM_PORTS-1:0][2:0] st;
    logic [NUM_PORTS-1:0]      relay;
  } port_bank_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        opcode = 1'b0;
  logic [2:0]  port = 3'd0;
  logic [2:0]  measured_state = 3'd0;
  logic [14:0] measured_age = 15'd0;
  logic        paused = 1'b0;
  logic        conditions_ok = 1'b0;
  logic [6:0]  current_amps = 7'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  port_out;
  logic [2:0]  state_now;
  logic        state_changed;
  logic        drive_valid;
  logic [9:0]  pilot_compare;
  logic        relay_on;
  logic        relay_toggled;
  logic        power_offered;

  pilot_item_t   pending_items[$];
  pilot_result_t expected_results[$];
  port_bank_t    plan_bank;
  port_bank_t    live_bank;
  pilot_item_t   load_it;
  pilot_item_t   taken_it;
  pilot_result_t exp_res;
  bit            in_taken = 1'b0;
  int            errors = 0;
  int            accepted = 0;
  int            results_seen = 0;
  int            moves_seen = 0;
  int            toggles_seen = 0;
  int            drives_seen = 0;
  int            cycle_count = 0;
  int            directed_count = 0;

  evse_pilot_state_controller_unit #(
    .PORT_COUNT(NUM_PORTS),
    .PWM_TOP(PWM_PERIOD)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .port(port),
    .measured_state(measured_state),
    .measured_age(measured_age),
    .paused(paused),
    .conditions_ok(conditions_ok),
    .current_amps(current_amps),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .port_out(port_out),
    .state_now(state_now),
    .state_changed(state_changed),
    .drive_valid(drive_valid),
    .pilot_compare(pilot_compare),
    .relay_on(relay_on),
    .relay_toggled(relay_toggled),
    .power_offered(power_offered)
  );

  function automatic logic offers_power(logic [2:0] st);
    return st == ST_WAIT || st == ST_CHARGE || st == ST_FAN;
  endfunction

  function automatic logic closes_relay(logic [2:0] st);
    return st == ST_CHARGE || st == ST_FAN || st == ST_PAUSED;
  endfunction

  function automatic logic [9:0] duty_for(logic [6:0] amps);
    int a;
    a = (amps > AMPS_CAP) ? AMPS_CAP : int'(amps);
    if (a < AMPS_KNEE) return 10'((a * (PWM_PERIOD / 5) + 6) / 12);
    return 10'((a * (PWM_PERIOD / 10) + 160 * (PWM_PERIOD / 10) + 12) / 25);
  endfunction

  function automatic pilot_result_t pilot_step(input pilot_item_t it, inout port_bank_t bank);
    pilot_result_t res;
    logic [2:0]    cur;
    logic [2:0]    nx;
    logic [2:0]    col;
    logic          want_relay;
    res = '0;
    res.port = it.port;
    if (it.port >= NUM_PORTS) return res;
    cur = bank.st[it.port];
    if (it.opcode == OP_STEP) begin
      col = it.paused ? 3'(ST_PAUSED) : it.meas;
      nx = NEXT_ST[cur][col];
      if (int'(it.age) >= HOLD_MIN[cur][col] && nx != cur && it.ok) begin
        want_relay = closes_relay(nx);
        cur = nx;
        bank.st[it.port] = nx;
        res.changed = 1'b1;
        res.drive = 1'b1;
        res.compare = offers_power(nx) ? duty_for(it.amps) : 10'(PWM_PERIOD);
        if (want_relay != bank.relay[it.port]) begin
          bank.relay[it.port] = want_relay;
          res.toggled = 1'b1;
        end
      end
    end else if (offers_power(cur)) begin
      res.drive = 1'b1;
      res.compare = duty_for(it.amps);
    end
    res.state = cur;
    res.relay = bank.relay[it.port];
    res.offered = offers_power(cur);
    return res;
  endfunction

  function automatic port_bank_t idle_bank();
    port_bank_t b;
    for (int i = 0; i < NUM_PORTS; i++) begin
      b.st[i] = ST_IDLE;
      b.relay[i] = 1'b0;
    end
    return b;
  endfunction

  function automatic pilot_item_t mk(logic op, logic [2:0] p, logic [2:0] m, logic [14:0] a,
                                     logic pz, logic k, logic [6:0] c);
    pilot_item_t it;
    it.opcode = op;
    it.port = p;
    it.meas = m;
    it.age = a;
    it.paused = pz;
    it.ok = k;
    it.amps = c;
    return it;
  endfunction

  function automatic logic [14:0] pick_age();
    case ($urandom_range(7))
      0: return 15'($urandom_range(12));
      1: return 15'($urandom_range(98, 102));
      2: return 15'($urandom_range(2498, 2502));
      3: return 15'd32767;
      default: return 15'($urandom_range(100, 32767));
    endcase
  endfunction

  function automatic logic [6:0] pick_amps();
    case ($urandom_range(9))
      0: return 7'($urandom_range(49, 51));
      1: return 7'($urandom_range(81, 127));
      default: return 7'($urandom_range(AMPS_CAP));
    endcase
  endfunction

  task automatic queue_item(input pilot_item_t it);
    void'(pilot_step(it, plan_bank));
    pending_items.push_back(it);
  endtask

  // biased toward moves out of the planned state so deep states get exercised
  function automatic pilot_item_t forward_step();
    pilot_item_t it;
    logic [2:0]  p;
    logic [2:0]  cur;
    p = 3'($urandom_range(NUM_PORTS - 1));
    cur = plan_bank.st[p];
    it = mk(OP_STEP, p, 3'($urandom_range(7)), pick_age(), 1'b0,
            $urandom_range(99) < 88, pick_amps());
    case (cur)
      ST_UNDEF: it.meas = $urandom_range(1) ? ST_IDLE : ST_DISCONNECT;
      ST_IDLE: it.meas = ST_CONNECT;
      ST_CONNECT: it.meas = $urandom_range(1) ? ST_CONNECT : ST_WAIT;
      ST_WAIT: it.meas = $urandom_range(1) ? ST_CHARGE : ST_FAN;
      ST_CHARGE, ST_FAN: begin
        if ($urandom_range(2) == 0) it.paused = 1'b1;
        else it.meas = 3'($urandom_range(3, 6));
      end
      ST_PAUSED: begin
        if ($urandom_range(2) == 0) it.paused = 1'b1;
        else it.meas = $urandom_range(1) ? ST_CONNECT : ST_DISCONNECT;
      end
      default: it.meas = $urandom_range(1) ? ST_IDLE : ST_CONNECT;
    endcase
    return it;
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("evse_pilot_state_controller_unit regression: fail");
      $finish;
    end
  end

  // driver: inputs move on the falling edge
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      if (pending_items.size() != 0 &&
          !((accepted < 450 || accepted >= 750) && $urandom_range(99) < 17)) begin
        load_it = pending_items.pop_front();
        opcode         <= load_it.opcode;
        port           <= load_it.port;
        measured_state <= load_it.meas;
        measured_age   <= load_it.age;
        paused         <= load_it.paused;
        conditions_ok  <= load_it.ok;
        current_amps   <= load_it.amps;
        in_valid       <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= (accepted >= 450 && accepted < 750) || $urandom_range(99) >= 17;
  end

  // monitor: sample both channels on the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && in_ready;
      if (in_taken) begin
        taken_it = mk(opcode, port, measured_state, measured_age, paused, conditions_ok,
                      current_amps);
        expected_results.push_back(pilot_step(taken_it, live_bank));
        accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected (port_out %0d)", port_out);
          errors++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("port_out", exp_res.port, port_out);
          check_field("state_now", exp_res.state, state_now);
          check_field("state_changed", exp_res.changed, state_changed);
          check_field("drive_valid", exp_res.drive, drive_valid);
          check_field("pilot_compare", exp_res.compare, pilot_compare);
          check_field("relay_on", exp_res.relay, relay_on);
          check_field("relay_toggled", exp_res.toggled, relay_toggled);
          check_field("power_offered", exp_res.offered, power_offered);
          moves_seen += exp_res.changed;
          toggles_seen += exp_res.toggled;
          drives_seen += exp_res.drive;
        end
      end
    end
  end

  initial begin
    int r;
    pilot_item_t it;
    plan_bank = idle_bank();
    live_bank = idle_bank();

    // directed: port 0 through connect, wait, charge, paused, idle, undefined and back to idle
    queue_item(mk(OP_REFRESH, 0, ST_IDLE, 0, 0, 1, 40));
    queue_item(mk(OP_STEP, 0, ST_CONNECT, 99, 0, 1, 0));
    queue_item(mk(OP_STEP, 0, ST_CONNECT, 100, 0, 0, 0));
    queue_item(mk(OP_STEP, 0, ST_CONNECT, 100, 0, 1, 0));
    queue_item(mk(OP_STEP, 0, ST_WAIT, 0, 0, 1, 0));
    queue_item(mk(OP_REFRESH, 0, ST_UNDEF, 0, 0, 0, 49));
    queue_item(mk(OP_REFRESH, 0, ST_UNDEF, 0, 0, 0, 50));
    queue_item(mk(OP_REFRESH, 0, ST_UNDEF, 0, 0, 0, 80));
    queue_item(mk(OP_REFRESH, 0, ST_UNDEF, 0, 0, 0, 127));
    queue_item(mk(OP_STEP, 0, ST_CHARGE, 100, 0, 1, 80));
    queue_item(mk(OP_STEP, 0, ST_UNDEF, 0, 1, 1, 32));
    queue_item(mk(OP_STEP, 0, ST_UNDEF, 2499, 1, 1, 32));
    queue_item(mk(OP_STEP, 0, ST_UNDEF, 2500, 1, 1, 32));
    // same state proposed: veto bit has no effect
    queue_item(mk(OP_STEP, 0, ST_IDLE, 32767, 0, 0, 0));
    queue_item(mk(OP_STEP, 0, ST_WAIT, 0, 0, 1, 0));
    queue_item(mk(OP_STEP, 0, ST_IDLE, 100, 0, 1, 0));
    // ports beyond the last one
    queue_item(mk(OP_REFRESH, 6, 7, 32767, 1, 1, 127));
    queue_item(mk(OP_STEP, 7, 7, 32767, 1, 1, 127));
    // port 5 through fan and back to idle
    queue_item(mk(OP_STEP, 5, ST_CONNECT, 100, 0, 1, 0));
    queue_item(mk(OP_STEP, 5, ST_CONNECT, 100, 0, 1, 0));
    queue_item(mk(OP_STEP, 5, ST_FAN, 32767, 0, 1, 63));
    queue_item(mk(OP_REFRESH, 5, ST_UNDEF, 0, 0, 0, 81));
    queue_item(mk(OP_STEP, 5, ST_DISCONNECT, 10, 0, 1, 0));
    directed_count = pending_items.size();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 12) begin
        it = mk(1'($urandom_range(1)), 3'($urandom_range(7)), 3'($urandom_range(7)),
                15'($urandom_range(32767)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                7'($urandom_range(127)));
      end else if (r < 35) begin
        it = mk(OP_REFRESH, 3'($urandom_range(NUM_PORTS - 1)), 3'($urandom_range(7)),
                pick_age(), 1'($urandom_range(1)), 1'($urandom_range(1)), pick_amps());
      end else begin
        it = forward_step();
      end
      queue_item(it);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d items (%0d directed), %0d results checked", accepted,
             directed_count, results_seen);
    $display("state moves %0d, relay toggles %0d, pilot updates %0d", moves_seen,
             toggles_seen, drives_seen);
    if (errors == 0) begin
      $display("evse_pilot_state_controller_unit regression: pass");
    end else begin
      $display("evse_pilot_state_controller_unit regression: fail");
    end
    $finish;
  end

endmodule
